@@ hw/rtl/hdp_pkg.sv @@
package hdp_pkg;

  // Short-item prefix fields
  localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
  localparam logic [2:0] FOUR_BYTES     = 3'd4;
  localparam logic [1:0] TYPE_LOCAL     = 2'd2;
  localparam logic [3:0] TAG_USAGE      = 4'd0;

  // Usage values of interest
  localparam logic [31:0] USAGE_X     = 32'h0000_0030;
  localparam logic [31:0] USAGE_Y     = 32'h0000_0031;
  localparam logic [31:0] USAGE_WHEEL = 32'h0000_0038;

  // Result constants
  localparam logic [14:0] AXIS_MAX   = 15'd32767;
  localparam logic [3:0]  MIN_LENGTH = 4'd10;
  localparam logic [1:0]  BUTTONS    = 2'd3;

  // Usages completed by the current byte
  typedef struct packed {
    logic x;
    logic y;
    logic wheel;
  } usage_hit_t;

endpackage

@@ hw/rtl/hdp_stream_if.sv @@
interface hdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       last_byte;

  modport source (output valid, output desc_byte, output last_byte, input ready);
  modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface

interface hdp_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [14:0] max_x;
  logic [14:0] max_y;
  logic        wheel_present;
  logic [1:0]  num_buttons;

  modport source (output valid, output ok, output max_x, output max_y,
                  output wheel_present, output num_buttons, input ready);
  modport sink   (input valid, input ok, input max_x, input max_y,
                  input wheel_present, input num_buttons, output ready);
endinterface

@@ hw/rtl/hdp_item_tracker.sv @@
// Tracks the current short item and flags usages completed by each byte.
module hdp_item_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          byte_in,
  input  logic                clear,
  output hdp_pkg::usage_hit_t hit
);
  import hdp_pkg::*;

  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [1:0]  byte_pos_r,   byte_pos_nxt;
  logic [1:0]  item_type_r,  item_type_nxt;
  logic [3:0]  item_tag_r,   item_tag_nxt;
  logic [31:0] item_value_r, item_value_nxt;
  logic        is_usage;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    byte_pos_nxt   = byte_pos_r;
    item_type_nxt  = item_type_r;
    item_tag_nxt   = item_tag_r;
    item_value_nxt = item_value_r;
    if (bytes_left_r == 3'd0) begin
      // prefix byte
      bytes_left_nxt = (byte_in[1:0] == SIZE_CODE_FOUR) ? FOUR_BYTES
                                                        : {1'b0, byte_in[1:0]};
      item_type_nxt  = byte_in[3:2];
      item_tag_nxt   = byte_in[7:4];
      item_value_nxt = 32'd0;
      byte_pos_nxt   = 2'd0;
    end else begin
      // data byte, little-endian
      item_value_nxt = item_value_r | ({24'd0, byte_in} << {byte_pos_r, 3'b000});
      byte_pos_nxt   = byte_pos_r + 2'd1;
      bytes_left_nxt = bytes_left_r - 3'd1;
    end
  end

  assign is_usage  = byte_en && (bytes_left_nxt == 3'd0) &&
                     (item_type_nxt == TYPE_LOCAL) && (item_tag_nxt == TAG_USAGE);
  assign hit.x     = is_usage && (item_value_nxt == USAGE_X);
  assign hit.y     = is_usage && (item_value_nxt == USAGE_Y);
  assign hit.wheel = is_usage && (item_value_nxt == USAGE_WHEEL);

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && clear)) begin
      bytes_left_r <= 3'd0;
      byte_pos_r   <= 2'd0;
      item_type_r  <= 2'd0;
      item_tag_r   <= 4'd0;
      item_value_r <= 32'd0;
    end else if (byte_en) begin
      bytes_left_r <= bytes_left_nxt;
      byte_pos_r   <= byte_pos_nxt;
      item_type_r  <= item_type_nxt;
      item_tag_r   <= item_tag_nxt;
      item_value_r <= item_value_nxt;
    end
  end

endmodule

@@ hw/rtl/hid_descriptor_item_parser_top.sv @@
// HID report descriptor short-item parser.
// in_chan carries one descriptor byte per transaction (desc_byte) with
// last_byte marking the final byte of a descriptor. out_chan carries one
// summary transaction per descriptor: ok, max_x, max_y, wheel_present and
// num_buttons. Bytes not flagged last produce no output transaction.
// Throughput: one byte per cycle while no summary is held up; each byte
// is decoded by short logic in the same cycle it is accepted and the
// summary lands in the output register, so out_chan.valid rises in the
// cycle after the last byte is taken.
// The output register frees the input side: in_chan.ready is low only while
// a summary is held and the receiver does not take it, so the parser
// stalls on a held result and resumes the cycle the receiver takes it.
// Reset (rst_n low, synchronous) clears the item tracker, the length count,
// the usage flags and the output valid; the next byte is taken as a prefix.
// After each summary the tracker, length count and usage flags are
// cleared, so the next byte starts a new descriptor.
module hid_descriptor_item_parser_top (
  input logic      clk,
  input logic      rst_n,
  hdp_in_if.sink   in_chan,
  hdp_out_if.source out_chan
);
  import hdp_pkg::*;

  logic       in_fire;
  logic       in_last;
  usage_hit_t hit;

  logic [3:0] length_r, length_nxt;
  logic       seen_x_r, seen_y_r, seen_wheel_r;
  logic       seen_x_nxt, seen_y_nxt, seen_wheel_nxt;
  logic       long_enough;

  logic        out_valid_r;
  logic        ok_r;
  logic [14:0] max_x_r, max_y_r;
  logic        wheel_present_r;
  logic [1:0]  num_buttons_r;

  // Hold off input only while a summary waits on the receiver
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_last       = in_fire && in_chan.last_byte;

  hdp_item_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (in_fire),
    .byte_in (in_chan.desc_byte),
    .clear   (in_chan.last_byte),
    .hit     (hit)
  );

  // Length saturates at the minimum; flags include a usage ending on this byte
  assign length_nxt     = (length_r < MIN_LENGTH) ? length_r + 4'd1 : length_r;
  assign long_enough    = (length_nxt >= MIN_LENGTH);
  assign seen_x_nxt     = seen_x_r     || hit.x;
  assign seen_y_nxt     = seen_y_r     || hit.y;
  assign seen_wheel_nxt = seen_wheel_r || hit.wheel;

  always_ff @(posedge clk) begin
    if (!rst_n || in_last) begin
      length_r     <= 4'd0;
      seen_x_r     <= 1'b0;
      seen_y_r     <= 1'b0;
      seen_wheel_r <= 1'b0;
    end else if (in_fire) begin
      length_r     <= length_nxt;
      seen_x_r     <= seen_x_nxt;
      seen_y_r     <= seen_y_nxt;
      seen_wheel_r <= seen_wheel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Summary payload; a short descriptor reports all zeros
  always_ff @(posedge clk) begin
    if (in_last) begin
      ok_r            <= long_enough;
      max_x_r         <= (long_enough && seen_x_nxt) ? AXIS_MAX : 15'd0;
      max_y_r         <= (long_enough && seen_y_nxt) ? AXIS_MAX : 15'd0;
      wheel_present_r <= long_enough && seen_wheel_nxt;
      num_buttons_r   <= long_enough ? BUTTONS : 2'd0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.ok            = ok_r;
  assign out_chan.max_x         = max_x_r;
  assign out_chan.max_y         = max_y_r;
  assign out_chan.wheel_present = wheel_present_r;
  assign out_chan.num_buttons   = num_buttons_r;

  // Last byte always yields a summary next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_last |=> out_chan.valid)
    else $error("last byte did not produce a summary");

  // Short descriptor reports zeros everywhere
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ok) |->
      (out_chan.max_x == 15'd0 && out_chan.max_y == 15'd0 &&
       !out_chan.wheel_present && out_chan.num_buttons == 2'd0))
    else $error("short descriptor summary not cleared");

  // Full descriptor always reports the button count
  a_ok_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ok) |-> (out_chan.num_buttons == BUTTONS))
    else $error("button count wrong on valid descriptor");

  // Input stalls only behind a held summary
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled without a pending summary");

  // Counters are cleared right after a summary is captured
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_last |=> (length_r == 4'd0 && !seen_x_r && !seen_y_r && !seen_wheel_r))
    else $error("descriptor state not cleared after last byte");

endmodule

@@ sim/hid_descriptor_item_parser_top_tb.sv @@
`timescale 1ns / 100ps

module hid_descriptor_item_parser_top_tb;
  import hdp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1200;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    logic        ok;
    logic [14:0] max_x;
    logic [14:0] max_y;
    logic        wheel_present;
    logic [1:0]  num_buttons;
  } summary_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_TOGGLE, RX_SPARSE} rx_mode_t;

  // Tracks the parser's view of the descriptor and keeps the summaries it owes
  class summary_scoreboard;
    logic [2:0]  data_left;
    logic [1:0]  data_pos;
    logic [1:0]  cur_type;
    logic [3:0]  cur_tag;
    logic [31:0] cur_value;
    logic [3:0]  seen_len;
    logic        got_x, got_y, got_wheel;
    summary_t    pending_summaries[$];
    int          errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      data_left = '0;
      data_pos  = '0;
      cur_type  = '0;
      cur_tag   = '0;
      cur_value = '0;
      seen_len  = '0;
      got_x     = 1'b0;
      got_y     = 1'b0;
      got_wheel = 1'b0;
    endfunction

    function void close_item();
      if (cur_type == TYPE_LOCAL && cur_tag == TAG_USAGE) begin
        if (cur_value == USAGE_X) got_x = 1'b1;
        if (cur_value == USAGE_Y) got_y = 1'b1;
        if (cur_value == USAGE_WHEEL) got_wheel = 1'b1;
      end
    endfunction

    // Accepted input transaction: advance the item tracker
    function void note_byte(logic [7:0] b, logic is_last);
      summary_t s;
      if (seen_len < MIN_LENGTH) seen_len++;
      if (data_left == 0) begin
        data_left = (b[1:0] == SIZE_CODE_FOUR) ? FOUR_BYTES : {1'b0, b[1:0]};
        cur_type  = b[3:2];
        cur_tag   = b[7:4];
        cur_value = '0;
        data_pos  = '0;
        if (data_left == 0) close_item();
      end else begin
        cur_value |= 32'(b) << (8 * data_pos);
        data_pos++;
        data_left--;
        if (data_left == 0) close_item();
      end
      if (!is_last) return;
      if (seen_len >= MIN_LENGTH) begin
        s.ok            = 1'b1;
        s.max_x         = got_x ? AXIS_MAX : '0;
        s.max_y         = got_y ? AXIS_MAX : '0;
        s.wheel_present = got_wheel;
        s.num_buttons   = BUTTONS;
      end else begin
        s = '{1'b0, '0, '0, 1'b0, '0};
      end
      pending_summaries.push_back(s);
      clear_state();
    endfunction

    task report(string what);
      if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Accepted output transaction: compare against the oldest summary owed
    task check_summary(logic ok, logic [14:0] mx, logic [14:0] my,
                       logic wh, logic [1:0] btn);
      summary_t s;
      if (pending_summaries.size() == 0) begin
        report("summary with none outstanding");
        return;
      end
      s = pending_summaries.pop_front();
      if (ok !== s.ok) report($sformatf("ok %b, want %b", ok, s.ok));
      if (mx !== s.max_x) report($sformatf("max_x %0d, want %0d", mx, s.max_x));
      if (my !== s.max_y) report($sformatf("max_y %0d, want %0d", my, s.max_y));
      if (wh !== s.wheel_present)
        report($sformatf("wheel_present %b, want %b", wh, s.wheel_present));
      if (btn !== s.num_buttons)
        report($sformatf("num_buttons %0d, want %0d", btn, s.num_buttons));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hdp_in_if  in_chan();
  hdp_out_if out_chan();

  hid_descriptor_item_parser_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  summary_scoreboard sb = new();

  int       cycles = 0;
  int       burst_left = 0;
  int       rx_phase_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  logic [7:0] desc_bytes[$];

  always #4 clk = ~clk;

  // Monitors: sample both channels at the rising edge, plus the watchdog
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_byte(in_chan.desc_byte, in_chan.last_byte);
      if (out_chan.valid && out_chan.ready)
        sb.check_summary(out_chan.ok, out_chan.max_x, out_chan.max_y,
                         out_chan.wheel_present, out_chan.num_buttons);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: switches between stall patterns at random.
  // Sparse mode holds results for long stretches, which also backs up
  // the input side since the parser stalls on a held summary.
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(16, 80);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      RX_ALWAYS: out_chan.ready <= 1'b1;
      RX_COIN:   out_chan.ready <= 1'($urandom_range(0, 1));
      RX_TOGGLE: out_chan.ready <= cycles[0];
      default:   out_chan.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Build a short-item prefix byte
  function automatic logic [7:0] prefix(logic [3:0] tag, logic [1:0] kind,
                                        logic [1:0] size_code);
    return {tag, kind, size_code};
  endfunction

  // One input transaction. Entered and left at a falling edge. Between
  // bursts valid drops for a random gap; a zero gap keeps valid high so
  // it never gets lowered and raised in the same step.
  task send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // every so often a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 12);
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.desc_byte <= b;
    in_chan.last_byte <= is_last;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Send desc_bytes as one descriptor, flagging the final byte
  task send_descriptor();
    foreach (desc_bytes[i]) send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
  endtask

  // Append a value as n little-endian data bytes
  task push_data(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) desc_bytes.push_back(v[8*i +: 8]);
  endtask

  // Append one item: mostly Usage items aimed at X, Y and wheel, with
  // near misses (wrong tag or type, junk in the upper bytes), and
  // arbitrary other items.
  task add_item();
    logic [1:0]  sc;
    logic [1:0]  kind;
    logic [3:0]  tag;
    logic [31:0] v;
    int          n;
    sc = 2'($urandom_range(0, 3));
    n  = (sc == SIZE_CODE_FOUR) ? 4 : int'(sc);
    if ($urandom_range(0, 9) < 6) begin
      kind = TYPE_LOCAL;
      tag  = TAG_USAGE;
      if ($urandom_range(0, 5) == 0) kind = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) tag = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 4))
        0:       v = USAGE_X;
        1:       v = USAGE_Y;
        2:       v = USAGE_WHEEL;
        default: v = 32'($urandom_range(0, 255));
      endcase
      if (n >= 2 && $urandom_range(0, 3) == 0) v[31:8] = 24'($urandom());
      if (n == 0) begin
        sc = 2'd1;
        n  = 1;
      end
    end else begin
      kind = 2'($urandom_range(0, 3));
      tag  = 4'($urandom_range(0, 15));
      v    = $urandom();
    end
    desc_bytes.push_back(prefix(tag, kind, sc));
    push_data(v, n);
  endtask

  // One random descriptor: mostly well-formed, some short, some long
  // (length count saturation), some noise, and a share cut off at a random byte.
  task build_descriptor();
    int target;
    int cut;
    desc_bytes.delete();
    case ($urandom_range(0, 9))
      0: begin
        target = $urandom_range(1, 30);
        repeat (target) desc_bytes.push_back(8'($urandom()));
      end
      1: target = $urandom_range(1, 9);
      2: target = $urandom_range(30, 60);
      default: target = $urandom_range(10, 24);
    endcase
    while (desc_bytes.size() < target) add_item();
    if ($urandom_range(0, 3) == 0 && desc_bytes.size() > 1) begin
      cut = $urandom_range(1, desc_bytes.size() - 1);
      while (desc_bytes.size() > cut) void'(desc_bytes.pop_back());
    end
  endtask

  initial begin
    int sent;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.desc_byte = '0;
    in_chan.last_byte = 1'b0;
    out_chan.ready    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Short descriptor: a lone all-ones byte, which is also a four-byte
    // prefix cut short by the end
    desc_bytes = {8'hFF};
    send_descriptor();

    // X and Y usages around an ignored four-byte item of all ones; the
    // wheel usage completes on the final byte itself
    desc_bytes = {prefix(TAG_USAGE, TYPE_LOCAL, 2'd1), USAGE_X[7:0],
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  prefix(TAG_USAGE, TYPE_LOCAL, 2'd1), USAGE_Y[7:0],
                  prefix(TAG_USAGE, TYPE_LOCAL, 2'd2), USAGE_WHEEL[7:0], 8'h00};
    send_descriptor();

    // Exactly ten bytes; the X usage at the end is cut short and dropped
    desc_bytes = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  prefix(TAG_USAGE, TYPE_LOCAL, SIZE_CODE_FOUR),
                  USAGE_X[7:0], 8'h00};
    send_descriptor();

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_descriptor();
      send_descriptor();
      sent += desc_bytes.size();
    end
    in_chan.valid <= 1'b0;

    // Drain; the watchdog covers a summary that never shows up
    while (sb.pending_summaries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_summaries.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
